// ----- hw/rtl/kce_pkg.sv -----
`default_nettype none
package kce_pkg;

   localparam int MAX_KEYS  = 64;
   localparam int FRAC_BITS = 16;
   localparam int SLOT_W    = $clog2(MAX_KEYS);
   localparam int COUNT_W   = 7;
   localparam int FX_W      = 32;

   // Segment position t runs from 0 to one inclusive.
   localparam int T_W       = FRAC_BITS + 1;
   // Divider works on positive 33-bit time differences.
   localparam int DIV_W     = FX_W + 1;
   // Shared multiplier operands, product and accumulator.
   localparam int MUL_A_W   = FX_W + 2;
   localparam int MUL_B_W   = T_W + 2;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = PROD_W + 3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam logic CSR_INTERP_MODE = 1'b0;
   localparam logic CSR_KEY_COUNT   = 1'b1;

   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_LINEAR = 2'd1;
   localparam logic [1:0] MODE_CUBIC  = 2'd2;
   localparam logic [1:0] MODE_TCB    = 2'd3;

   localparam logic [1:0] SRC_BASE   = 2'd0;
   localparam logic [1:0] SRC_HELD   = 2'd1;
   localparam logic [1:0] SRC_INTERP = 2'd2;

   typedef struct packed {
      logic                   operation;
      logic [SLOT_W-1:0]      slot;
      logic signed [FX_W-1:0] key_time;
      logic signed [FX_W-1:0] key_value;
      logic signed [FX_W-1:0] tangent_in;
      logic signed [FX_W-1:0] tangent_out;
      logic                   hold_flag;
      logic signed [FX_W-1:0] query_time;
      logic signed [FX_W-1:0] base_value;
   } req_type;

   typedef struct packed {
      logic signed [FX_W-1:0] curve_value;
      logic [1:0]             value_source;
   } rsp_type;

   typedef struct packed {
      logic signed [FX_W-1:0] key_time;
      logic signed [FX_W-1:0] key_value;
      logic signed [FX_W-1:0] tangent_in;
      logic signed [FX_W-1:0] tangent_out;
      logic                   hold_flag;
   } key_rec_type;

   localparam int REC_W = $bits(key_rec_type);

   typedef struct packed {
      logic                   cubic;
      logic [T_W-1:0]         t;
      logic signed [FX_W-1:0] v0;
      logic signed [FX_W-1:0] v1;
      logic signed [FX_W-1:0] tout;
      logic signed [FX_W-1:0] tin;
   } blend_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAST,
      ST_SEARCH,
      ST_NEXT,
      ST_HELD,
      ST_START,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } ctrl_state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/keyframe_curve_evaluator.sv -----
`default_nettype none
// Keyframe curve evaluator. Write items load one keyframe (time, value, incoming and
// outgoing tangent, hold flag) into a 64-entry table; evaluate items return the curve
// value at a query time, as a held key value, a linear blend or a cubic Hermite blend
// of the segment that holds the time, or the base value in mode none or when the key
// count is zero. All values are signed Q16.16 and the result is saturated to 32 bits.
// Keys must be written in time order and below key_count before they are evaluated.
// The block works on one item at a time. An evaluate item that needs the table makes
// one table read per step of the binary search, at most six steps; a blend then runs
// the bit-serial divider that forms the segment position and the steps of the single
// shared multiplier, eight for a cubic blend. A finished result waits in the output
// register, so the next item is taken while it is pending.
// The user must write configuration (interp_mode at index 0, key_count at index 1)
// only while the block is idle; the block itself does not enforce this.
module keyframe_curve_evaluator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire kce_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output kce_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic                            csr_index,
   input  wire logic [kce_pkg::COUNT_W-1:0]     csr_data
);
   import kce_pkg::*;

   logic [1:0]          mode_ff, mode_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                ram_we;
   logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
   logic [REC_W-1:0]    ram_wdata, ram_rdata;
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_num, div_den;
   logic [FRAC_BITS-1:0] div_quot;
   logic                blend_start, blend_done;
   blend_req_type       blend_req;
   logic signed [FX_W-1:0] blend_value;

   // The register port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERP_MODE: mode_in  = csr_data[1:0];
            CSR_KEY_COUNT:   count_in = csr_data;
            default:         mode_in  = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NONE;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   // Whole keyframe records live in one table; writes and searches never overlap.
   kce_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   kce_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   kce_blend u_blend (
      .clock (clock),
      .reset (reset),
      .start (blend_start),
      .req   (blend_req),
      .done  (blend_done),
      .value (blend_value)
   );

   kce_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mode        (mode_ff),
      .key_count   (count_ff),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .div_start   (div_start),
      .div_num     (div_num),
      .div_den     (div_den),
      .div_done    (div_done),
      .div_quot    (div_quot),
      .blend_start (blend_start),
      .blend_req   (blend_req),
      .blend_done  (blend_done),
      .blend_value (blend_value)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/kce_ram.sv -----
`default_nettype none
module kce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/kce_div.sv -----
`default_nettype none
module kce_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [kce_pkg::DIV_W-1:0]     num,
   input  wire logic [kce_pkg::DIV_W-1:0]     den,
   output logic                               done,
   output logic [kce_pkg::FRAC_BITS-1:0]      quot
);
   import kce_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [DIV_W:0]       shifted;
   logic                 fits;
   logic                 last_step;

   // Restoring division, one quotient bit a cycle; the remainder stays below den.
   always_comb begin
      shifted   = {rem_ff, 1'b0};
      fits      = shifted >= {1'b0, den_ff};
      last_step = cnt_ff == CNT_W'(FRAC_BITS - 1);
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quot_in   = quot_ff;
      done_in   = busy_ff && last_step;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_W'(shifted - {1'b0, den_ff}) : DIV_W'(shifted);
         quot_in = {quot_ff[FRAC_BITS-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/kce_blend.sv -----
`default_nettype none
module kce_blend (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire kce_pkg::blend_req_type         req,
   output logic                                done,
   output logic signed [kce_pkg::FX_W-1:0]     value
);
   import kce_pkg::*;

   localparam logic [2:0] STEP_SQUARE = 3'd0;
   localparam logic [2:0] STEP_CUBE   = 3'd1;
   localparam logic [2:0] STEP_KEEP   = 3'd2;
   localparam logic [2:0] STEP_H00    = 3'd3;
   localparam logic [2:0] STEP_H01    = 3'd4;
   localparam logic [2:0] STEP_H10    = 3'd5;
   localparam logic [2:0] STEP_H11    = 3'd6;
   localparam logic [2:0] STEP_LAST   = 3'd7;
   localparam logic signed [MUL_B_W-1:0] ONE_B = MUL_B_W'(1) <<< FRAC_BITS;
   localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'((64'sd1 <<< (FX_W - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] MIN_V = -(ACC_W'(64'sd1 <<< (FX_W - 1)));

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [T_W-1:0]           t2_ff, t2_in, t3_ff, t3_in;
   logic [T_W-1:0]           t2_c;
   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [MUL_B_W-1:0] t_s, t2_s, t3_s, h00, h01, h10, h11;
   logic signed [ACC_W-1:0]  shifted;
   logic                     add_prod, finish;

   // Hermite basis weights from t, t^2 and t^3, all at FRAC_BITS.
   always_comb begin
      t2_c = prod_ff[FRAC_BITS +: T_W];
      t_s  = signed'(MUL_B_W'(req.t));
      t2_s = signed'(MUL_B_W'(t2_ff));
      t3_s = signed'(MUL_B_W'(t3_ff));
      h00  = (t3_s + t3_s) - (t2_s + t2_s + t2_s) + ONE_B;
      h01  = (t2_s + t2_s + t2_s) - (t3_s + t3_s);
      h10  = t3_s - (t2_s + t2_s) + t_s;
      h11  = t3_s - t2_s;
   end

   // One multiply a cycle; the product is registered and summed in the cycle after.
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (!req.cubic) begin
         op_a = MUL_A_W'(req.v1) - MUL_A_W'(req.v0);
         op_b = t_s;
      end else begin
         unique case (cnt_ff)
            STEP_SQUARE: begin
               op_a = signed'(MUL_A_W'(req.t));
               op_b = t_s;
            end
            STEP_CUBE: begin
               op_a = signed'(MUL_A_W'(t2_c));
               op_b = t_s;
            end
            STEP_H00: begin
               op_a = MUL_A_W'(req.v0);
               op_b = h00;
            end
            STEP_H01: begin
               op_a = MUL_A_W'(req.v1);
               op_b = h01;
            end
            STEP_H10: begin
               op_a = MUL_A_W'(req.tout);
               op_b = h10;
            end
            STEP_H11: begin
               op_a = MUL_A_W'(req.tin);
               op_b = h11;
            end
            STEP_KEEP, STEP_LAST: begin
               op_a = '0;
               op_b = '0;
            end
            default: begin
               op_a = '0;
               op_b = '0;
            end
         endcase
      end
   end

   always_comb begin
      add_prod = req.cubic ? (cnt_ff >= STEP_H01) : (cnt_ff == STEP_CUBE);
      finish   = req.cubic ? (cnt_ff == STEP_LAST) : (cnt_ff == STEP_CUBE);
      prod_in  = op_a * op_b;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      t2_in    = t2_ff;
      t3_in    = t3_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_SQUARE;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == STEP_SQUARE) begin
            acc_in = req.cubic ? '0 : (ACC_W'(req.v0) <<< FRAC_BITS);
         end else if (add_prod) begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
         if (req.cubic && cnt_ff == STEP_CUBE) begin
            t2_in = t2_c;
         end
         if (req.cubic && cnt_ff == STEP_KEEP) begin
            t3_in = prod_ff[FRAC_BITS +: T_W];
         end
         if (finish) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      t2_ff   <= t2_in;
      t3_ff   <= t3_in;
   end

   // Arithmetic shift is the floor; then saturate to 32 bits.
   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      if (shifted > MAX_V) begin
         value = MAX_V[FX_W-1:0];
      end else if (shifted < MIN_V) begin
         value = MIN_V[FX_W-1:0];
      end else begin
         value = shifted[FX_W-1:0];
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/kce_ctrl.sv -----
`default_nettype none
module kce_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire kce_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output kce_pkg::rsp_type                      rsp_data,
   input  wire logic [1:0]                       mode,
   input  wire logic [kce_pkg::COUNT_W-1:0]      key_count,
   output logic                                  ram_we,
   output logic [kce_pkg::SLOT_W-1:0]            ram_waddr,
   output logic [kce_pkg::REC_W-1:0]             ram_wdata,
   output logic [kce_pkg::SLOT_W-1:0]            ram_raddr,
   input  wire logic [kce_pkg::REC_W-1:0]        ram_rdata,
   output logic                                  div_start,
   output logic [kce_pkg::DIV_W-1:0]             div_num,
   output logic [kce_pkg::DIV_W-1:0]             div_den,
   input  wire logic                             div_done,
   input  wire logic [kce_pkg::FRAC_BITS-1:0]    div_quot,
   output logic                                  blend_start,
   output kce_pkg::blend_req_type                blend_req,
   input  wire logic                             blend_done,
   input  wire logic signed [kce_pkg::FX_W-1:0]  blend_value
);
   import kce_pkg::*;

   localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

   ctrl_state_type state_ff, state_in;
   logic signed [FX_W-1:0] q_ff, q_in;
   logic [SLOT_W-1:0]      last_ff, last_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [SLOT_W-1:0]      mid_ff, mid_in, idx_ff, idx_in;
   logic signed [FX_W-1:0] t1_ff, t1_in, v1_ff, v1_in, tin_ff, tin_in;
   logic signed [FX_W-1:0] v0_ff, v0_in, tout_ff, tout_in;
   logic                   cubic_ff, cubic_in;
   logic [T_W-1:0]         t_ff, t_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   key_rec_type            rec, wrec;
   logic                   accept, eval_none, q_nonpos, at_end, go_hi;
   logic [COUNT_W-1:0]     n_sat;
   logic [SLOT_W-1:0]      last_c, lo_nx, hi_nx, mid_nx, after_addr;
   logic [SLOT_W:0]        pair_sum;
   logic                   search_more, idx_last;
   logic signed [DIV_W-1:0] num, den;
   logic                   den_nonpos, num_nonpos, num_ge, frac_mid, out_free;

   assign rec       = key_rec_type'(ram_rdata);
   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      n_sat     = (key_count > COUNT_W'(MAX_KEYS)) ? COUNT_W'(MAX_KEYS) : key_count;
      last_c    = SLOT_W'(n_sat - COUNT_W'(1));
      eval_none = mode == MODE_NONE || key_count == '0;
      q_nonpos  = req_data.query_time <= 0;
      at_end    = q_ff >= rec.key_time;
      go_hi     = rec.key_time > q_ff;
   end

   // Search window after this cycle's compare, and the next probe.
   always_comb begin
      lo_nx = lo_ff;
      hi_nx = hi_ff;
      if (state_ff == ST_LAST) begin
         lo_nx = '0;
         hi_nx = last_ff;
      end else if (state_ff == ST_SEARCH) begin
         lo_nx = go_hi ? lo_ff : mid_ff;
         hi_nx = go_hi ? mid_ff : hi_ff;
      end
      pair_sum    = {1'b0, lo_nx} + {1'b0, hi_nx};
      mid_nx      = pair_sum[SLOT_W:1];
      search_more = (hi_nx - lo_nx) > SLOT_W'(1);
      idx_last    = lo_nx == last_ff;
      after_addr  = idx_last ? lo_nx : lo_nx + SLOT_W'(1);
   end

   always_comb begin
      num        = DIV_W'(q_ff) - DIV_W'(rec.key_time);
      den        = DIV_W'(t1_ff) - DIV_W'(rec.key_time);
      den_nonpos = den <= 0;
      num_nonpos = num <= 0;
      num_ge     = num >= den;
      frac_mid   = !num_nonpos && !num_ge;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.operation == OP_EVAL) begin
               if (eval_none) begin
                  state_in = ST_DONE;
               end else if (q_nonpos) begin
                  state_in = ST_HELD;
               end else begin
                  state_in = ST_LAST;
               end
            end
         end
         ST_LAST: begin
            if (at_end) begin
               state_in = ST_HELD;
            end else if (search_more) begin
               state_in = ST_SEARCH;
            end else begin
               state_in = idx_last ? ST_HELD : ST_NEXT;
            end
         end
         ST_SEARCH: begin
            if (search_more) begin
               state_in = ST_SEARCH;
            end else begin
               state_in = idx_last ? ST_HELD : ST_NEXT;
            end
         end
         ST_NEXT:  state_in = rec.hold_flag ? ST_HELD : ST_START;
         ST_HELD:  state_in = ST_DONE;
         ST_START: begin
            if (den_nonpos) begin
               state_in = ST_DONE;
            end else if (frac_mid) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_DIV:   state_in = div_done ? ST_MUL : ST_DIV;
         ST_MUL:   state_in = blend_done ? ST_DONE : ST_MUL;
         ST_DONE:  state_in = out_free ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wrec.key_time    = req_data.key_time;
      wrec.key_value   = req_data.key_value;
      wrec.tangent_in  = req_data.tangent_in;
      wrec.tangent_out = req_data.tangent_out;
      wrec.hold_flag   = req_data.hold_flag;
      ram_we       = accept && req_data.operation == OP_WRITE;
      ram_waddr    = req_data.slot;
      ram_wdata    = wrec;
      ram_raddr    = idx_ff;
      q_in         = q_ff;
      last_in      = last_ff;
      lo_in        = lo_nx;
      hi_in        = hi_nx;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      t1_in        = t1_ff;
      v1_in        = v1_ff;
      tin_in       = tin_ff;
      v0_in        = v0_ff;
      tout_in      = tout_ff;
      cubic_in     = cubic_ff;
      t_in         = t_ff;
      res_in       = res_ff;
      div_start    = 1'b0;
      blend_start  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            q_in     = req_data.query_time;
            last_in  = last_c;
            cubic_in = mode == MODE_CUBIC;
            res_in.curve_value  = req_data.base_value;
            res_in.value_source = SRC_BASE;
            ram_raddr = q_nonpos ? '0 : last_c;
            idx_in    = q_nonpos ? '0 : last_c;
         end
         ST_LAST, ST_SEARCH: begin
            if (state_ff == ST_LAST && at_end) begin
               ram_raddr = last_ff;
               idx_in    = last_ff;
            end else if (search_more) begin
               ram_raddr = mid_nx;
               mid_in    = mid_nx;
            end else begin
               ram_raddr = after_addr;
               idx_in    = lo_nx;
            end
         end
         ST_NEXT: begin
            t1_in  = rec.key_time;
            v1_in  = rec.key_value;
            tin_in = rec.tangent_in;
         end
         ST_HELD: begin
            res_in.curve_value  = rec.key_value;
            res_in.value_source = SRC_HELD;
         end
         ST_START: begin
            v0_in   = rec.key_value;
            tout_in = rec.tangent_out;
            res_in.curve_value  = rec.key_value;
            res_in.value_source = SRC_HELD;
            t_in        = num_nonpos ? '0 : T_ONE;
            div_start   = !den_nonpos && frac_mid;
            blend_start = !den_nonpos && !frac_mid;
         end
         ST_DIV: begin
            if (div_done) begin
               t_in        = {1'b0, div_quot};
               blend_start = 1'b1;
            end
         end
         ST_MUL: begin
            if (blend_done) begin
               res_in.curve_value  = blend_value;
               res_in.value_source = SRC_INTERP;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   assign div_num = num;
   assign div_den = den;

   always_comb begin
      blend_req.cubic = cubic_ff;
      blend_req.t     = t_ff;
      blend_req.v0    = v0_ff;
      blend_req.v1    = v1_ff;
      blend_req.tout  = tout_ff;
      blend_req.tin   = tin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff        <= q_in;
      last_ff     <= last_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      idx_ff      <= idx_in;
      t1_ff       <= t1_in;
      v1_ff       <= v1_in;
      tin_ff      <= tin_in;
      v0_ff       <= v0_in;
      tout_ff     <= tout_in;
      cubic_ff    <= cubic_in;
      t_ff        <= t_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
